### rtl/llpa_pkg.sv
`default_nettype none

package llpa_pkg;

  // Store depth and derived index widths.
  localparam int MAX_PARTS = 512;
  localparam int PART_W    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W     = PART_W + 1;

  // Fixed field widths.
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 10;
  localparam int OUT_IDX_W = 9;
  localparam int STEP_W   = $clog2(DATA_W);

  localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(384);
  localparam logic [DATA_W-1:0] SAT_VAL      = {DATA_W{1'b1}};

  // Request kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_UPD   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Number of partitions actually scanned: zero counts as one, and the
  // value is capped at the store depth.
  function automatic logic [CNT_W-1:0] clamp_parts(input logic [CFG_W-1:0] ap);
    logic [CNT_W-1:0] p;
    if (ap == '0) begin
      p = CNT_W'(1);
    end else if (int'(ap) > MAX_PARTS) begin
      p = CNT_W'(MAX_PARTS);
    end else begin
      p = CNT_W'(ap);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/llpa_if.sv
`default_nettype none

interface llpa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [llpa_pkg::DATA_W-1:0] degree;
  logic [llpa_pkg::DATA_W-1:0] remaining;

  modport source (output valid, kind, degree, remaining, input ready);
  modport sink   (input valid, kind, degree, remaining, output ready);
endinterface

interface llpa_out_if;
  logic                           valid;
  logic                           ready;
  logic [llpa_pkg::OUT_IDX_W-1:0] part_index;
  logic [llpa_pkg::DATA_W-1:0]    take_count;
  logic [llpa_pkg::DATA_W-1:0]    part_load;
  logic [llpa_pkg::DATA_W-1:0]    part_count;

  modport source (output valid, part_index, take_count, part_load, part_count, input ready);
  modport sink   (input valid, part_index, take_count, part_load, part_count, output ready);
endinterface

`default_nettype wire

### rtl/llpa_ram.sv
`default_nettype none

module llpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/llpa_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module llpa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [llpa_pkg::DATA_W-1:0]       dividend,
  input  logic [llpa_pkg::CNT_W-1:0]        divisor,
  output logic [llpa_pkg::DATA_W-1:0]       quotient,
  output llpa_pkg::div_stat_t               stat
);

  logic                          busy_r;
  logic [llpa_pkg::STEP_W-1:0]   cnt_r;
  logic [llpa_pkg::CNT_W-1:0]    rem_r;
  logic [llpa_pkg::CNT_W-1:0]    dvs_r;
  logic [llpa_pkg::DATA_W-1:0]   quo_r;
  logic [llpa_pkg::CNT_W:0]      shifted;
  logic [llpa_pkg::CNT_W:0]      diff;
  logic                          ge;
  logic                          last;

  assign shifted = {rem_r, quo_r[llpa_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign last    = cnt_r == llpa_pkg::STEP_W'(llpa_pkg::DATA_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[llpa_pkg::CNT_W-1:0] : shifted[llpa_pkg::CNT_W-1:0];
      quo_r <= {quo_r[llpa_pkg::DATA_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = busy_r && last;

endmodule

`default_nettype wire

### rtl/least_loaded_partition_assign_top.sv
// Greedy least-loaded partition assignment. Each partition has an edge load
// and a vertex count, both zeroed by a clearing pass over all 512 entries
// after reset, during which no request is taken (the cfg port still works). A
// request reads the first P partitions one per cycle through the single read
// port of each store (P is active_parts, zero taken as one, capped at 512);
// a weighted request whose spread exceeds its degree then runs the
// bit-serial divider to size a batch before the chosen entry is updated.
// One request is in flight at a time; a finished result sits in the output
// register so the next request can be taken while it waits.
`default_nettype none

module least_loaded_partition_assign_top (
  input  logic                             clk,
  input  logic                             rst_n,
  llpa_in_if.sink                          in_ch,
  llpa_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [llpa_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int DW = llpa_pkg::DATA_W;
  localparam int PW = llpa_pkg::PART_W;
  localparam int CW = llpa_pkg::CNT_W;

  llpa_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]                  clr_r, clr_nxt;
  logic [llpa_pkg::CFG_W-1:0]     ap_r;
  logic                           kind_r;
  logic [DW-1:0]                  degree_r;
  logic [DW-1:0]                  remaining_r;
  logic [CW-1:0]                  p_r;
  logic [CW-1:0]                  iss_r, iss_nxt;
  logic                           rvld_r, rvld_nxt;
  logic [PW-1:0]                  ridx_r, ridx_nxt;
  logic [DW-1:0]                  mn_r, mn_nxt;
  logic [DW-1:0]                  mx_r, mx_nxt;
  logic [PW-1:0]                  pos_r, pos_nxt;
  logic                           go_div_r, go_div_nxt;
  logic [DW-1:0]                  take_r;
  logic [2*DW-1:0]                prod_r;
  logic [DW-1:0]                  load_r;
  logic [DW-1:0]                  cnt_r;
  logic                           out_valid_r;
  logic [llpa_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic [DW-1:0]                  out_take_r;
  logic [DW-1:0]                  out_load_r;
  logic [DW-1:0]                  out_cnt_r;

  logic                           in_xfer;
  logic                           out_free;
  logic                           issue;
  logic [PW-1:0]                  raddr;
  logic [DW-1:0]                  el_rdata;
  logic [DW-1:0]                  vc_rdata;
  logic [DW-1:0]                  scan_val;
  logic [DW-1:0]                  spread;
  logic [DW-1:0]                  quot;
  llpa_pkg::div_stat_t            div_stat;
  logic                           div_start;
  logic [DW-1:0]                  take_sel;
  logic [2*DW-1:0]                prod_c;
  logic [DW:0]                    ld_sum;
  logic [DW:0]                    cn_sum;
  logic [DW-1:0]                  new_load;
  logic [DW-1:0]                  new_cnt;
  logic                           ram_we;
  logic [PW-1:0]                  waddr;
  logic [DW-1:0]                  el_wdata;
  logic [DW-1:0]                  vc_wdata;

  assign in_ch.ready = state_r == llpa_pkg::ST_IDLE;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // The output register can take a new result when it is empty or is being
  // emptied in this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;

  // Scan read path: one address is issued per cycle, the data comes back in
  // the cycle after. Outside the scan the read port stays on the chosen entry.
  assign issue    = (state_r == llpa_pkg::ST_SCAN) && (iss_r < p_r);
  assign raddr    = issue ? iss_r[PW-1:0] : pos_r;
  assign scan_val = (kind_r == llpa_pkg::KIND_COUNT) ? vc_rdata : el_rdata;
  assign spread   = mx_r - mn_r;

  // A batch is taken only when the spread test passed and the quotient
  // exceeds one; otherwise a single vertex is placed.
  assign take_sel = (go_div_r && (quot > DW'(1))) ? quot : DW'(1);
  assign prod_c   = (2*DW)'(degree_r) * (2*DW)'(take_sel);

  // Saturating updates. A vertex-count request leaves the load unchanged.
  assign ld_sum   = {1'b0, load_r} + {1'b0, prod_r[DW-1:0]};
  assign new_load = (kind_r == llpa_pkg::KIND_COUNT) ? load_r :
                    ((|prod_r[2*DW-1:DW]) || ld_sum[DW]) ? llpa_pkg::SAT_VAL :
                    ld_sum[DW-1:0];
  assign cn_sum   = {1'b0, cnt_r} + {1'b0, take_r};
  assign new_cnt  = cn_sum[DW] ? llpa_pkg::SAT_VAL : cn_sum[DW-1:0];

  // Both stores share one write address: the clearing pass writes zeros,
  // the update writes the chosen entry once, when the result is handed over.
  assign ram_we   = (state_r == llpa_pkg::ST_CLEAR) ||
                    ((state_r == llpa_pkg::ST_UPD) && out_free);
  assign waddr    = (state_r == llpa_pkg::ST_CLEAR) ? clr_r : pos_r;
  assign el_wdata = (state_r == llpa_pkg::ST_CLEAR) ? '0 : new_load;
  assign vc_wdata = (state_r == llpa_pkg::ST_CLEAR) ? '0 : new_cnt;

  llpa_ram #(.WIDTH(DW), .DEPTH(llpa_pkg::MAX_PARTS)) u_edge_load (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (el_wdata),
    .raddr (raddr),
    .rdata (el_rdata)
  );

  llpa_ram #(.WIDTH(DW), .DEPTH(llpa_pkg::MAX_PARTS)) u_vertex_count (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (vc_wdata),
    .raddr (raddr),
    .rdata (vc_rdata)
  );

  llpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (remaining_r),
    .divisor  (p_r),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Sequencer. The scan keeps a running minimum (first index wins on ties)
  // and a running maximum of the selected store.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    iss_nxt    = iss_r;
    rvld_nxt   = 1'b0;
    ridx_nxt   = ridx_r;
    mn_nxt     = mn_r;
    mx_nxt     = mx_r;
    pos_nxt    = pos_r;
    go_div_nxt = go_div_r;
    div_start  = 1'b0;
    case (state_r)
      llpa_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PW'(llpa_pkg::MAX_PARTS - 1)) begin
          state_nxt = llpa_pkg::ST_IDLE;
        end
      end
      llpa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          iss_nxt   = '0;
          state_nxt = llpa_pkg::ST_SCAN;
        end
      end
      llpa_pkg::ST_SCAN: begin
        if (issue) begin
          iss_nxt  = iss_r + 1'b1;
          rvld_nxt = 1'b1;
          ridx_nxt = iss_r[PW-1:0];
        end
        if (rvld_r) begin
          if (ridx_r == '0) begin
            mn_nxt  = scan_val;
            mx_nxt  = scan_val;
            pos_nxt = '0;
          end else begin
            if (scan_val < mn_r) begin
              mn_nxt  = scan_val;
              pos_nxt = ridx_r;
            end
            if (scan_val > mx_r) begin
              mx_nxt = scan_val;
            end
          end
          if (CW'(ridx_r) == p_r - CW'(1)) begin
            state_nxt = llpa_pkg::ST_FETCH;
          end
        end
      end
      llpa_pkg::ST_FETCH: begin
        go_div_nxt = (kind_r == llpa_pkg::KIND_LOAD) && (spread > degree_r);
        div_start  = go_div_nxt;
        state_nxt  = go_div_nxt ? llpa_pkg::ST_DIV : llpa_pkg::ST_MUL;
      end
      llpa_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = llpa_pkg::ST_MUL;
        end
      end
      llpa_pkg::ST_MUL: begin
        state_nxt = llpa_pkg::ST_UPD;
      end
      llpa_pkg::ST_UPD: begin
        if (out_free) begin
          state_nxt = llpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = llpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llpa_pkg::ST_CLEAR;
      clr_r       <= '0;
      ap_r        <= llpa_pkg::ACTIVE_RESET;
      rvld_r      <= 1'b0;
      go_div_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      rvld_r   <= rvld_nxt;
      go_div_r <= go_div_nxt;
      if (cfg_we) begin
        ap_r <= cfg_wdata;
      end
      if ((state_r == llpa_pkg::ST_UPD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_r  <= iss_nxt;
    ridx_r <= ridx_nxt;
    mn_r   <= mn_nxt;
    mx_r   <= mx_nxt;
    pos_r  <= pos_nxt;
    if (in_xfer) begin
      kind_r      <= in_ch.kind;
      degree_r    <= in_ch.degree;
      remaining_r <= in_ch.remaining;
      p_r         <= llpa_pkg::clamp_parts(ap_r);
    end
    if (state_r == llpa_pkg::ST_MUL) begin
      take_r <= take_sel;
      prod_r <= prod_c;
      load_r <= el_rdata;
      cnt_r  <= vc_rdata;
    end
    if ((state_r == llpa_pkg::ST_UPD) && out_free) begin
      out_idx_r  <= llpa_pkg::OUT_IDX_W'(pos_r);
      out_take_r <= take_r;
      out_load_r <= new_load;
      out_cnt_r  <= new_cnt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.part_index = out_idx_r;
  assign out_ch.take_count = out_take_r;
  assign out_ch.part_load  = out_load_r;
  assign out_ch.part_count = out_cnt_r;

endmodule

`default_nettype wire

### rtl/llpa_checker.sv
`default_nettype none

module llpa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [llpa_pkg::OUT_IDX_W-1:0]   out_part_index,
  input logic [llpa_pkg::DATA_W-1:0]      out_take_count,
  input logic [llpa_pkg::DATA_W-1:0]      out_part_load,
  input logic [llpa_pkg::DATA_W-1:0]      out_part_count
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_part_index) && $stable(out_take_count) &&
                                $stable(out_part_load) && $stable(out_part_count))
    else $error("result payload changed while stalled");

  // A request is worked on alone: the block is busy right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the scan started");

  // Every request places at least one vertex, so the count is never zero.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_take_count != '0) && (out_part_count != '0))
    else $error("result places no vertex");

endmodule

bind least_loaded_partition_assign_top llpa_checker u_llpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_part_index (out_ch.part_index),
  .out_take_count (out_ch.take_count),
  .out_part_load  (out_ch.part_load),
  .out_part_count (out_ch.part_count)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

// One expected placement, in the widths of the result channel.
typedef struct packed {
  logic [llpa_pkg::OUT_IDX_W-1:0] part_index;
  logic [llpa_pkg::DATA_W-1:0]    take_count;
  logic [llpa_pkg::DATA_W-1:0]    part_load;
  logic [llpa_pkg::DATA_W-1:0]    part_count;
} placement_t;

// Mirrors the partition stores and predicts where each request lands.
class placement_scoreboard;
  logic [llpa_pkg::DATA_W-1:0] edge_load [llpa_pkg::MAX_PARTS];
  logic [llpa_pkg::DATA_W-1:0] vertex_count [llpa_pkg::MAX_PARTS];
  logic [llpa_pkg::CFG_W-1:0]  parts_cfg;
  placement_t                  expected_q[$];
  int                          mismatches;

  function new();
    foreach (edge_load[i]) begin
      edge_load[i] = '0;
      vertex_count[i] = '0;
    end
    parts_cfg = llpa_pkg::ACTIVE_RESET;
    mismatches = 0;
  endfunction

  function void set_parts(logic [llpa_pkg::CFG_W-1:0] value);
    parts_cfg = value;
  endfunction

  // Applies one accepted request to the mirrored stores and queues the result.
  function void note_request(logic kind, logic [llpa_pkg::DATA_W-1:0] degree,
                             logic [llpa_pkg::DATA_W-1:0] remaining);
    int unsigned                 scan;
    int unsigned                 pos;
    int unsigned                 j;
    logic [llpa_pkg::DATA_W-1:0] lowest;
    logic [llpa_pkg::DATA_W-1:0] highest;
    logic [llpa_pkg::DATA_W-1:0] quotient;
    logic [llpa_pkg::DATA_W-1:0] take;
    logic [63:0]                 wide;
    placement_t                  want;

    // A zero setting still scans one partition; large ones stop at the store depth.
    if (parts_cfg == '0) scan = 1;
    else if (int'(parts_cfg) > llpa_pkg::MAX_PARTS) scan = llpa_pkg::MAX_PARTS;
    else scan = 32'(parts_cfg);
    pos = 0;
    take = 1;

    if (kind == llpa_pkg::KIND_LOAD) begin
      lowest = edge_load[0];
      highest = edge_load[0];
      for (j = 1; j < scan; j++) begin
        if (edge_load[j] < lowest) begin
          lowest = edge_load[j];
          pos = j;
        end
        if (edge_load[j] > highest) highest = edge_load[j];
      end
      if (highest - lowest > degree) begin
        quotient = remaining / scan;
        if (quotient > 1) take = quotient;
      end
      wide = 64'(edge_load[pos]) + 64'(degree) * 64'(take);
      edge_load[pos] = (wide > 64'(llpa_pkg::SAT_VAL)) ? llpa_pkg::SAT_VAL : wide[31:0];
    end else begin
      lowest = vertex_count[0];
      for (j = 1; j < scan; j++) begin
        if (vertex_count[j] < lowest) begin
          lowest = vertex_count[j];
          pos = j;
        end
      end
    end
    wide = 64'(vertex_count[pos]) + 64'(take);
    vertex_count[pos] = (wide > 64'(llpa_pkg::SAT_VAL)) ? llpa_pkg::SAT_VAL : wide[31:0];

    want.part_index = pos[llpa_pkg::OUT_IDX_W-1:0];
    want.take_count = take;
    want.part_load = edge_load[pos];
    want.part_count = vertex_count[pos];
    expected_q.push_back(want);
  endfunction

  function void check_result(logic [llpa_pkg::OUT_IDX_W-1:0] idx,
                             logic [llpa_pkg::DATA_W-1:0] take,
                             logic [llpa_pkg::DATA_W-1:0] load,
                             logic [llpa_pkg::DATA_W-1:0] count);
    placement_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result: part %0d take %0d load %0d count %0d",
                 idx, take, load, count);
      return;
    end
    want = expected_q.pop_front();
    if (want.part_index !== idx || want.take_count !== take ||
        want.part_load !== load || want.part_count !== count) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected part %0d take %0d load %0d count %0d, ",
                  "got part %0d take %0d load %0d count %0d"},
                 want.part_index, want.take_count, want.part_load, want.part_count,
                 idx, take, load, count);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int failures();
    return mismatches + expected_q.size();
  endfunction
endclass

module testbench;
  // The watchdog trips after this many cycles without a transfer on either
  // channel. The limit covers the slowest request, the clearing pass after
  // reset, and the sender gaps and receiver stalls on top of them.
  localparam int STALL_LIMIT = 4000;
  // Cycles allowed after the last result before the verdict; this covers
  // the longest request latency at the full partition count.
  localparam int DRAIN_CYCLES = 600;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [llpa_pkg::CFG_W-1:0] cfg_wdata;

  llpa_in_if  in_ch();
  llpa_out_if out_ch();

  least_loaded_partition_assign_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  placement_scoreboard sb;

  // Sender burst state: requests left in the current burst.
  int burst_left;
  // Receiver pattern state: how long the current ready level is held.
  int sink_hold;
  logic sink_level;
  int quiet_cycles;

  always #10 clk = ~clk;

  // The receiver alternates between hard stalls, long stretches of continuous
  // ready, and short choppy periods where ready toggles almost every cycle.
  // The pattern runs independently of the sender so that stalls land on
  // every phase of a request.
  always @(posedge clk) begin
    if (sink_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          sink_level = 1'b0;
          sink_hold = $urandom_range(1, 20);
        end
        1: begin
          sink_level = 1'b1;
          sink_hold = $urandom_range(20, 200);
        end
        default: begin
          sink_level = 1'($urandom_range(0, 1));
          sink_hold = $urandom_range(1, 4);
        end
      endcase
    end else begin
      sink_hold--;
    end
    out_ch.ready <= sink_level;
  end

  // Every result transfer is checked against the oldest prediction. Values
  // are sampled at the edge, before any update scheduled for that edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.part_index, out_ch.take_count, out_ch.part_load,
                      out_ch.part_count);
  end

  // The watchdog counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and waits for its transfer. When the current burst is
  // used up, valid drops for a random gap, so valid is never lowered and
  // raised within the same time step. The prediction is made by the driver at
  // the accepting edge so a later drain check can never miss a request that
  // was just taken.
  task automatic send_request(input logic kind, input logic [llpa_pkg::DATA_W-1:0] degree,
                              input logic [llpa_pkg::DATA_W-1:0] remaining);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.degree <= degree;
    in_ch.remaining <= remaining;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(kind, degree, remaining);
    burst_left--;
  endtask

  // Stops offering requests and waits until every predicted result is back.
  // Each request produces exactly one result, so an empty queue means the
  // block is idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Changes the partition count only while the block is idle.
  task automatic set_active_parts(input logic [llpa_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_parts(value);
  endtask

  // Random traffic for one partition count. Weighted requests mostly come as
  // degree classes: one degree with a remaining count that shrinks from one
  // request to the next, the way a placement pass walks through a class.
  // Degrees are mostly small so that loads stay apart for a while and
  // batches keep happening; now and then a full-range degree or remaining
  // count pushes entries into saturation. Vertex-balance requests are mixed
  // in with random values in the ignored fields.
  task automatic run_random(input logic [llpa_pkg::CFG_W-1:0] parts, input int count);
    int unsigned                 scan;
    int unsigned                 step;
    logic [llpa_pkg::DATA_W-1:0] class_degree;
    logic [llpa_pkg::DATA_W-1:0] class_left;

    set_active_parts(parts);
    scan = (parts == '0) ? 1 : ((int'(parts) > llpa_pkg::MAX_PARTS) ?
                                llpa_pkg::MAX_PARTS : 32'(parts));
    class_left = '0;
    class_degree = '0;
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        send_request(llpa_pkg::KIND_COUNT, $urandom, $urandom);
      end else begin
        if (class_left == '0 || $urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 15))
            0:       class_degree = $urandom;
            1, 2:    class_degree = $urandom_range(0, 65535);
            default: class_degree = $urandom_range(0, 63);
          endcase
          case ($urandom_range(0, 15))
            0:       class_left = '0;
            1:       class_left = $urandom;
            2, 3:    class_left = $urandom_range(1, 65536);
            default: class_left = $urandom_range(1, 8 * scan + 8);
          endcase
        end
        send_request(llpa_pkg::KIND_LOAD, class_degree, class_left);
        step = $urandom_range(1, 4);
        class_left = (class_left > step) ? class_left - step : '0;
      end
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = llpa_pkg::KIND_LOAD;
    in_ch.degree = '0;
    in_ch.remaining = '0;
    out_ch.ready = 1'b0;
    burst_left = 0;
    sink_hold = 0;
    sink_level = 1'b0;
    quiet_cycles = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A few requests at the reset partition count, before any write, to
    // confirm the reset setting and the cleared stores. The third one finds
    // a spread above its degree and places a batch.
    send_request(llpa_pkg::KIND_COUNT, 32'd0, 32'd0);
    send_request(llpa_pkg::KIND_LOAD, 32'd5, 32'd1000);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'd100000);

    // Directed corner cases on two partitions: maximum-size batches that
    // drive a vertex count into saturation, a zero remaining count, a
    // quotient of exactly one, a spread equal to the degree, ties broken
    // toward the lower index, loads saturated by full-range degrees, and
    // vertex-balance requests with extreme values in the ignored fields.
    set_active_parts(10'd2);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'hFFFF_FFFF);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'hFFFF_FFFF);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'd0);
    send_request(llpa_pkg::KIND_LOAD, 32'd1, 32'd3);
    send_request(llpa_pkg::KIND_LOAD, 32'd4, 32'd4);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'd7);
    send_request(llpa_pkg::KIND_LOAD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(llpa_pkg::KIND_LOAD, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(llpa_pkg::KIND_LOAD, 32'hFFFF_FFFF, 32'd2);
    send_request(llpa_pkg::KIND_LOAD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(llpa_pkg::KIND_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(llpa_pkg::KIND_COUNT, 32'd0, 32'd0);
    send_request(llpa_pkg::KIND_LOAD, 32'd0, 32'hFFFF_FFFF);
    send_request(llpa_pkg::KIND_LOAD, 32'h8000_0000, 32'h8000_0000);
    send_request(llpa_pkg::KIND_LOAD, 32'h7FFF_FFFF, 32'd1);

    // Random phases with a growing partition count, so each phase brings in
    // partitions that are still empty while the earlier ones carry load. A
    // zero setting must behave as one partition; the two largest settings
    // exercise the cap at the store depth and the full scan.
    run_random(10'd0, 70);
    run_random(10'd1, 70);
    run_random(10'd3, 140);
    run_random(10'd5, 150);
    run_random(10'd9, 170);
    run_random(10'd17, 170);
    run_random(10'd33, 150);
    run_random(10'd64, 120);
    run_random(10'd1023, 40);
    run_random(10'd512, 40);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d predicted results never arrived", sb.pending());
    if (sb.failures() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
